/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Every macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

/* sv/lmkc_pkg.sv */
// ----------------------------------------------------------------------------
// lmkc_pkg
// Types and constants for the keyed device cache that uses
// least-frequently-used replacement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lmkc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ADDR_W  = 48;
	localparam int TIME_W  = 48;
	localparam int STR_W   = 8;
	localparam int CNT_W   = 32;
	localparam int SLOT_W  = 4;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic        [ADDR_W-1:0] device_address;
		logic signed [STR_W-1:0]  signal_strength;
		logic        [TIME_W-1:0] arrival_time;
	} item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_index;
		logic              was_hit;
		logic              replaced_valid;
		logic [ADDR_W-1:0] evicted_address;
		logic [CNT_W-1:0]  use_count;
	} result_t;

	// One cache line as it sits in the entry memory.
	typedef struct packed {
		logic        [ADDR_W-1:0] key;
		logic signed [STR_W-1:0]  strength;
		logic        [CNT_W-1:0]  count;
		logic        [TIME_W-1:0] stamp;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE
	} state_t;

endpackage

`default_nettype wire

/* sv/lfu_mac_keyed_cache.sv */
// ----------------------------------------------------------------------------
// lfu_mac_keyed_cache
// Fully associative device cache keyed by a 48-bit address, with
// least-frequently-used replacement.
// ----------------------------------------------------------------------------
// Each input beat is one arrival. The block scans all ENTRIES slots of the
// entry memory, one slot per cycle, through one shared compare stage. That
// stage looks for a matching key, the first empty slot and the replacement
// victim: lowest count, then oldest time, then lowest index. An arrival is
// accepted, then the slots are read in turn, then the registered read data
// of the last slot drains, then the slot is written and the result register
// loaded; the write waits while a held result is stalled. The input stalls
// for the whole scan. A finished result waits in its output register while
// the next arrival is scanned. There is no clearing pass after reset: a
// per-slot occupied bit qualifies the hit and empty-slot checks, and the
// victim is used only when every slot is occupied.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lfu_mac_keyed_cache (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    item_valid,
	output logic                   item_stall,
	input  wire lmkc_pkg::item_t   item,
	output logic                   result_valid,
	input  wire                    result_stall,
	output lmkc_pkg::result_t      result
);
	import lmkc_pkg::*;

	entry_t entry_mem [ENTRIES];

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   rd_idx_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	entry_t             ent_s1;
	logic [ENTRIES-1:0] occ_q;
	item_t              item_q;

	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [CNT_W-1:0]   hit_cnt_q;
	logic               empty_q;
	logic [IDX_W-1:0]   empty_idx_q;
	logic [IDX_W-1:0]   vic_idx_q;
	logic [CNT_W-1:0]   vic_cnt_q;
	logic [TIME_W-1:0]  vic_time_q;
	logic [ADDR_W-1:0]  vic_key_q;

	result_t            result_q;
	logic               result_valid_q;

	logic               accept;
	logic               issue;
	logic               wr_go;
	logic               last_idx;
	logic               slot_occ;
	logic               key_match;
	logic               vic_take;
	logic [IDX_W-1:0]   wr_idx;
	logic [CNT_W-1:0]   new_cnt;
	entry_t             wr_ent;
	logic               replace;

	assign accept   = item_valid && !item_stall;
	assign last_idx = (rd_idx_q == IDX_W'(ENTRIES - 1));

	// Sequencer: next state and the strobes for reading and writing.
	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		issue      = 1'b0;
		wr_go      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (last_idx) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (!result_valid_q || !result_stall) begin
					wr_go   = 1'b1;
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			idx_s1   <= '0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			idx_s1  <= rd_idx_q;
			if (accept) rd_idx_q <= '0;
			else if (issue) rd_idx_q <= rd_idx_q + 1'b1;
		end
	end

	// Entry memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_go) entry_mem[wr_idx] <= wr_ent;
		ent_s1 <= entry_mem[rd_idx_q];
	end

	// Shared compare stage, which looks at one slot per cycle.
	assign slot_occ  = occ_q[idx_s1];
	assign key_match = (ent_s1.key == item_q.device_address);
	assign vic_take  = (idx_s1 == '0) || (ent_s1.count < vic_cnt_q) ||
		((ent_s1.count == vic_cnt_q) && (ent_s1.stamp < vic_time_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
		end else if (accept) begin
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
		end else if (vld_s1) begin
			if (slot_occ && key_match && !hit_q) hit_q <= 1'b1;
			if (!slot_occ && !empty_q) empty_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_q <= item;
		if (vld_s1) begin
			if (slot_occ && key_match && !hit_q) begin
				hit_idx_q <= idx_s1;
				hit_cnt_q <= ent_s1.count;
			end
			if (!slot_occ && !empty_q) empty_idx_q <= idx_s1;
			if (vic_take) begin
				vic_idx_q  <= idx_s1;
				vic_cnt_q  <= ent_s1.count;
				vic_time_q <= ent_s1.stamp;
				vic_key_q  <= ent_s1.key;
			end
		end
	end

	// Choose the slot to write and build the updated entry.
	assign replace = !hit_q && !empty_q;

	always_comb begin
		if (hit_q) wr_idx = hit_idx_q;
		else if (empty_q) wr_idx = empty_idx_q;
		else wr_idx = vic_idx_q;

		if (!hit_q) new_cnt = CNT_W'(1);
		else if (hit_cnt_q == COUNT_MAX) new_cnt = COUNT_MAX;
		else new_cnt = hit_cnt_q + 1'b1;

		wr_ent.key      = item_q.device_address;
		wr_ent.strength = item_q.signal_strength;
		wr_ent.count    = new_cnt;
		wr_ent.stamp    = item_q.arrival_time;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (wr_go) occ_q[wr_idx] <= 1'b1;
			if (wr_go) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_go) begin
			result_q.slot_index      <= SLOT_W'(wr_idx);
			result_q.was_hit         <= hit_q;
			result_q.replaced_valid  <= replace;
			result_q.evicted_address <= replace ? vic_key_q : '0;
			result_q.use_count       <= new_cnt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_NEXT(a_accept_starts_scan, accept, (state_q == ST_SCAN) && (rd_idx_q == '0))
	`ASSERT_SAME(a_hit_not_replaced, result_valid_q,
		!(result_q.was_hit && result_q.replaced_valid))
	`ASSERT_SAME(a_count_nonzero, result_valid_q, result_q.use_count != '0)
	`ASSERT_SAME(a_replace_only_full, wr_go && replace, &occ_q)

endmodule

`default_nettype wire
